>>> rtl/core/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [31:0] BCAST_IP = 32'hffff_ffff;
	localparam logic [47:0] MAC_ALL_ONES = 48'hffff_ffff_ffff;
	localparam logic [15:0] OPC_REQUEST = 16'd1;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] REG_HOST_IP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOST_MAC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEV_PRESENT = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [15:0] arp_opcode;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [31:0] target_ip;
		logic [31:0] query_ip;
	} in_item_t;

	typedef struct packed {
		logic             send_reply;
		logic [47:0]      reply_mac;
		logic [31:0]      reply_ip;
		logic             hit;
		logic [47:0]      found_mac;
		logic [CNT_W-1:0] entry_count;
	} out_item_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} entry_t;

	typedef struct packed {
		logic [31:0] host_ip;
		logic        device_present;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/arp_cache_responder_top.sv
// ARP cache and responder.
// Input channel (in_valid / in_stall / in_item): each item is a received ARP
// packet (operation 0) or a lookup of query_ip (operation 1). One result item
// leaves on the output channel (out_valid / out_stall / out_item) per input.
// Configuration (cfg_we / cfg_index / cfg_data) sets host_ip and
// device_present and ignores host_mac; write only while the block is idle.
// Timing: the IP/MAC table sits in one single-port-read RAM and is searched
// one entry per cycle from slot 0 up to the fill count N seen at acceptance.
// An item goes from ST_IDLE through ST_SCAN, then ST_WRITE when the sender is
// learned, then ST_DONE; it goes straight from ST_IDLE to ST_DONE when no
// search is needed (broadcast key, dropped request).
// From ST_DONE the result is loaded into the output register, which raises
// out_valid; the next item can be taken once the engine is back in ST_IDLE.
// in_stall is high while an item is being worked on. A finished result sits
// in the output register, so the next item is taken while it waits; if the
// receiver still stalls when the following result is ready, the block holds.
// Reset empties the table (fill count and insert pointer to zero) and clears
// the configuration; no clearing pass is needed.
`default_nettype none

module arp_cache_responder_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire arpc_pkg::in_item_t                 in_item,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output arpc_pkg::out_item_t                     out_item,
	input  wire logic                               cfg_we,
	input  wire logic [arpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [arpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	arpc_pkg::cfg_t      cfg_q;
	arpc_pkg::out_item_t res;
	arpc_pkg::out_item_t out_item_q;
	logic                out_valid_q;
	logic                busy;
	logic                res_valid;
	logic                res_stall;
	logic                res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				arpc_pkg::REG_HOST_IP: cfg_q.host_ip <= cfg_data[31:0];
				arpc_pkg::REG_DEV_PRESENT: cfg_q.device_present <= cfg_data[0];
				// host MAC writes are not stored in this block
				arpc_pkg::REG_HOST_MAC: cfg_q <= cfg_q;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_stall = busy;
	assign res_stall = out_valid_q && out_stall;
	assign res_load = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	arpc_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.start(in_valid && !in_stall),
		.item(in_item),
		.busy(busy),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

endmodule

`default_nettype wire

>>> rtl/core/arpc_ram.sv
`default_nettype none

module arpc_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 512,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/arpc_engine.sv
`default_nettype none

module arpc_engine (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire arpc_pkg::cfg_t       cfg,
	input  wire logic                 start,
	input  wire arpc_pkg::in_item_t   item,
	output logic                      busy,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output arpc_pkg::out_item_t       res
);

	arpc_pkg::state_t state_q, state_d;

	arpc_pkg::in_item_t item_q;
	logic [31:0] key_q;
	logic        lookup_q;
	logic        reply_q;
	logic        need_ins_q;
	logic        found_q;
	logic [47:0] found_mac_q;

	logic [arpc_pkg::CNT_W-1:0]  idx_q;
	logic                        pend_s1;
	logic [arpc_pkg::ADDR_W-1:0] ptr_q;
	logic [arpc_pkg::CNT_W-1:0]  count_q;

	logic [31:0] key_in;
	logic        req_us;
	logic        need_ins;
	logic        bcast;
	logic        need_scan;
	logic        accept;

	logic            rd_en;
	logic            we;
	logic            match;
	arpc_pkg::entry_t rd_data;
	arpc_pkg::entry_t wr_data;

	// classify the incoming item
	always_comb begin
		key_in = item.operation ? item.query_ip : item.sender_ip;
		req_us = !item.operation && (item.arp_opcode == arpc_pkg::OPC_REQUEST)
			&& (item.target_ip == cfg.host_ip);
		// a request to us with no device is neither answered nor learned
		need_ins = !item.operation && !(req_us && !cfg.device_present);
		bcast = (key_in == arpc_pkg::BCAST_IP);
		need_scan = (item.operation || need_ins) && !bcast;
	end

	assign accept = start && (state_q == arpc_pkg::ST_IDLE);
	assign match = pend_s1 && (rd_data.ip == key_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			arpc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = need_scan ? arpc_pkg::ST_SCAN : arpc_pkg::ST_DONE;
				end
			end
			arpc_pkg::ST_SCAN: begin
				if (match) begin
					state_d = arpc_pkg::ST_DONE;
				end else if (!rd_en) begin
					state_d = need_ins_q ? arpc_pkg::ST_WRITE : arpc_pkg::ST_DONE;
				end
			end
			arpc_pkg::ST_WRITE: begin
				state_d = arpc_pkg::ST_DONE;
			end
			arpc_pkg::ST_DONE: begin
				if (!res_stall) begin
					state_d = arpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = arpc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = (state_q != arpc_pkg::ST_IDLE);
		res_valid = (state_q == arpc_pkg::ST_DONE);
		we = (state_q == arpc_pkg::ST_WRITE);
		// only slots below the fill count hold learned entries
		rd_en = (state_q == arpc_pkg::ST_SCAN) && (idx_q < count_q);
		wr_data.ip = item_q.sender_ip;
		wr_data.mac = item_q.sender_mac;
		res.send_reply = reply_q;
		res.reply_mac = reply_q ? item_q.sender_mac : '0;
		res.reply_ip = reply_q ? item_q.sender_ip : '0;
		res.hit = lookup_q && found_q;
		res.found_mac = (lookup_q && found_q) ? found_mac_q : '0;
		res.entry_count = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arpc_pkg::ST_IDLE;
			idx_q <= '0;
			pend_s1 <= 1'b0;
			found_q <= 1'b0;
			ptr_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= rd_en;
			if (accept) begin
				found_q <= bcast;
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (match) begin
				found_q <= 1'b1;
			end
			if (we) begin
				if (ptr_q == arpc_pkg::ADDR_W'(arpc_pkg::TABLE_DEPTH - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
				if (count_q != arpc_pkg::CNT_W'(arpc_pkg::TABLE_DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			key_q <= key_in;
			lookup_q <= item.operation;
			reply_q <= req_us && cfg.device_present;
			need_ins_q <= need_ins;
			found_mac_q <= bcast ? arpc_pkg::MAC_ALL_ONES : '0;
		end else if (match) begin
			found_mac_q <= rd_data.mac;
		end
	end

	arpc_ram #(
		.WIDTH($bits(arpc_pkg::entry_t)),
		.DEPTH(arpc_pkg::TABLE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(we),
		.wr_addr(ptr_q),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(idx_q[arpc_pkg::ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= arpc_pkg::CNT_W'(arpc_pkg::TABLE_DEPTH))
		else $error("fill count above table depth");

	// until the table is full, the insert slot is the next unfilled one
	a_ptr_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != arpc_pkg::CNT_W'(arpc_pkg::TABLE_DEPTH))
		|-> (ptr_q == count_q[arpc_pkg::ADDR_W-1:0]))
		else $error("insert pointer out of step with fill count");

	a_no_dup_insert: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (!found_q && need_ins_q && !lookup_q))
		else $error("table write for a resolved or non-learning item");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (count_q != arpc_pkg::CNT_W'(arpc_pkg::TABLE_DEPTH)))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("fill count did not advance on insert");

endmodule

`default_nettype wire
